// File: rtl/efb_pkg.sv
`timescale 1ns / 1ps

package efb_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_TRAILER = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  localparam logic [2:0] CFG_START       = 3'd0;
  localparam logic [2:0] CFG_END         = 3'd1;
  localparam logic [2:0] CFG_ESCAPE      = 3'd2;
  localparam logic [2:0] CFG_ESC_END     = 3'd3;
  localparam logic [2:0] CFG_ESC_ESCAPE  = 3'd4;
  localparam logic [2:0] CFG_LINK_ADDR   = 3'd5;

  // header token steps
  localparam logic [2:0] HDR_START   = 3'd0;
  localparam logic [2:0] HDR_ADDR    = 3'd1;
  localparam logic [2:0] HDR_NUMBER  = 3'd2;
  localparam logic [2:0] HDR_KIND    = 3'd3;
  localparam logic [2:0] HDR_COMMAND = 3'd4;

  localparam logic [7:0] SUM_INVERT = 8'hff;
  localparam logic [7:0] COUNTER_RESET = 8'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // one wire byte before escaping
  typedef struct packed {
    logic [7:0] data;
    logic       content;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_end_code;
    logic [7:0] escaped_escape_code;
  } esc_codes_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] counter;
  } front_stat_t;

endpackage

// File: rtl/efb_front.sv
`timescale 1ns / 1ps

module efb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         start_code_i,
  input  logic [7:0]         end_code_i,
  input  logic [7:0]         link_address_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         command_code_i,
  input  logic [7:0]         kind_of_frame_i,
  input  logic               use_given_number_i,
  input  logic [7:0]         given_number_i,
  input  logic [7:0]         data_byte_i,
  output logic               push_o,
  output efb_pkg::token_t    tok_o,
  input  logic               full_i,
  output efb_pkg::front_stat_t stat_o
);

  logic             busy_q, busy_d;
  efb_pkg::mode_e   mode_q, mode_d;
  logic [2:0]       step_q, step_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       kind_q, kind_d;
  logic [7:0]       num_q, num_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       counter_q, counter_d;
  logic [7:0]       sum_q, sum_d;
  efb_pkg::token_t  tok;
  efb_pkg::mode_e   in_mode;
  logic             accept;
  logic             done;

  assign in_mode = efb_pkg::mode_e'(mode_i);

  always_comb begin
    tok = '0;
    case (mode_q)
      efb_pkg::MODE_HEADER: begin
        case (step_q)
          efb_pkg::HDR_START:   tok = '{data: start_code_i, content: 1'b0, last: 1'b0};
          efb_pkg::HDR_ADDR:    tok = '{data: link_address_i, content: 1'b1, last: 1'b0};
          efb_pkg::HDR_NUMBER:  tok = '{data: num_q, content: 1'b1, last: 1'b0};
          efb_pkg::HDR_KIND:    tok = '{data: kind_q, content: 1'b1, last: 1'b0};
          efb_pkg::HDR_COMMAND: tok = '{data: cmd_q, content: 1'b1, last: 1'b1};
          default:              tok = '{data: cmd_q, content: 1'b1, last: 1'b1};
        endcase
      end
      efb_pkg::MODE_PAYLOAD: tok = '{data: data_q, content: 1'b1, last: 1'b1};
      efb_pkg::MODE_TRAILER: begin
        if (step_q == 3'd0) begin
          tok = '{data: sum_q ^ efb_pkg::SUM_INVERT, content: 1'b1, last: 1'b0};
        end else begin
          tok = '{data: end_code_i, content: 1'b0, last: 1'b1};
        end
      end
      default: tok = '0;
    endcase
  end

  assign push_o     = busy_q && !full_i;
  assign done       = push_o && tok.last;
  assign in_ready_o = !busy_q || done;
  assign accept     = in_valid_i && in_ready_o;
  assign tok_o      = tok;
  assign stat_o     = '{busy: busy_q, counter: counter_q};

  always_comb begin
    busy_d    = busy_q;
    mode_d    = mode_q;
    step_d    = step_q;
    cmd_d     = cmd_q;
    kind_d    = kind_q;
    num_d     = num_q;
    data_d    = data_q;
    counter_d = counter_q;
    sum_d     = sum_q;
    // running sum follows each token as it leaves
    if (push_o) begin
      if (mode_q == efb_pkg::MODE_HEADER && step_q == efb_pkg::HDR_START) begin
        sum_d = '0;
      end else if (tok.content) begin
        sum_d = sum_q + tok.data;
      end
    end
    if (accept) begin
      busy_d = (in_mode != efb_pkg::MODE_NONE);
      mode_d = in_mode;
      step_d = '0;
      cmd_d  = command_code_i;
      kind_d = kind_of_frame_i;
      data_d = data_byte_i;
      num_d  = use_given_number_i ? given_number_i : counter_q;
      if (in_mode == efb_pkg::MODE_HEADER && !use_given_number_i) begin
        counter_d = counter_q + 8'd1;
      end
    end else if (done) begin
      busy_d = 1'b0;
    end else if (push_o) begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      mode_q    <= efb_pkg::MODE_NONE;
      step_q    <= '0;
      counter_q <= efb_pkg::COUNTER_RESET;
      sum_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      mode_q    <= mode_d;
      step_q    <= step_d;
      counter_q <= counter_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    kind_q <= kind_d;
    num_q  <= num_d;
    data_q <= data_d;
  end

endmodule

// File: rtl/efb_fifo.sv
`timescale 1ns / 1ps

module efb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  efb_pkg::token_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output efb_pkg::token_t pop_data_o,
  output logic            empty_o
);

  efb_pkg::token_t                  mem_q [efb_pkg::FIFO_DEPTH];
  logic [efb_pkg::FIFO_AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [efb_pkg::FIFO_CW-1:0]      count_q;

  assign full_o     = (count_q == efb_pkg::FIFO_CW'(efb_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + efb_pkg::FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + efb_pkg::FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + efb_pkg::FIFO_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - efb_pkg::FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/efb_back.sv
`timescale 1ns / 1ps

module efb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efb_pkg::esc_codes_t codes_i,
  input  efb_pkg::token_t    tok_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       pend_q, pend_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_last_q, pend_last_d;
  logic       load;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_last_d = pend_last_q;
    if (load) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        // send the substitute that follows an escape
        out_valid_d = 1'b1;
        out_byte_d  = pend_byte_q;
        out_last_d  = pend_last_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        pend_last_d = tok_i.last;
        if (tok_i.content && tok_i.data == codes_i.end_code) begin
          out_byte_d  = codes_i.escape_code;
          out_last_d  = 1'b0;
          pend_d      = 1'b1;
          pend_byte_d = codes_i.escaped_end_code;
        end else if (tok_i.content && tok_i.data == codes_i.escape_code) begin
          out_byte_d  = codes_i.escape_code;
          out_last_d  = 1'b0;
          pend_d      = 1'b1;
          pend_byte_d = codes_i.escaped_escape_code;
        end else begin
          out_byte_d = tok_i.data;
          out_last_d = tok_i.last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    pend_byte_q <= pend_byte_d;
    pend_last_q <= pend_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// File: rtl/escaped_frame_builder_unit.sv
`timescale 1ns / 1ps
// An accepted item is registered in the front end and its tokens pass the token queue;
// the back end's output register sends one wire byte per cycle while out_ready_i is
// high and tokens wait. Bytes per item: payload 1 (2 escaped), header 5-9, trailer 2-3.
// The front end pushes one token per cycle while the 4-entry token queue has room and
// takes the next item in the cycle that it pushes the last token of the current one.
// Reset: asynchronous active low; codes clear to 0, frame counter to 1, sum to 0.
module escaped_frame_builder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] kind_of_frame_i,
  input  logic       use_given_number_i,
  input  logic [7:0] given_number_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic [7:0] start_code_q, end_code_q, escape_code_q;
  logic [7:0] esc_end_q, esc_escape_q, link_address_q;

  efb_pkg::esc_codes_t  codes;
  efb_pkg::front_stat_t front_stat;
  efb_pkg::token_t      push_tok, pop_tok;
  logic                 push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q   <= '0;
      end_code_q     <= '0;
      escape_code_q  <= '0;
      esc_end_q      <= '0;
      esc_escape_q   <= '0;
      link_address_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        efb_pkg::CFG_START:      start_code_q   <= cfg_data_i;
        efb_pkg::CFG_END:        end_code_q     <= cfg_data_i;
        efb_pkg::CFG_ESCAPE:     escape_code_q  <= cfg_data_i;
        efb_pkg::CFG_ESC_END:    esc_end_q      <= cfg_data_i;
        efb_pkg::CFG_ESC_ESCAPE: esc_escape_q   <= cfg_data_i;
        efb_pkg::CFG_LINK_ADDR:  link_address_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign codes = '{end_code: end_code_q, escape_code: escape_code_q,
                   escaped_end_code: esc_end_q, escaped_escape_code: esc_escape_q};

  efb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_code_i       (start_code_q),
    .end_code_i         (end_code_q),
    .link_address_i     (link_address_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .command_code_i     (command_code_i),
    .kind_of_frame_i    (kind_of_frame_i),
    .use_given_number_i (use_given_number_i),
    .given_number_i     (given_number_i),
    .data_byte_i        (data_byte_i),
    .push_o             (push),
    .tok_o              (push_tok),
    .full_i             (full),
    .stat_o             (front_stat)
  );

  efb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_tok),
    .empty_o     (empty)
  );

  efb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .codes_i       (codes),
    .tok_i         (pop_tok),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("token pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("token popped from empty queue");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !front_stat.busy |-> in_ready_o)
    else $error("idle front end refuses an item");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == efb_pkg::MODE_HEADER && !use_given_number_i)
    |=> front_stat.counter == $past(front_stat.counter) + 8'd1)
    else $error("frame counter did not advance on header");

endmodule

// File: sim/tb_escaped_frame_builder_unit.sv
`timescale 1ns / 1ps

module tb_escaped_frame_builder_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct {
    efb_pkg::mode_e mode;
    logic [7:0]     command;
    logic [7:0]     kind;
    logic           use_given;
    logic [7:0]     given;
    logic [7:0]     data;
  } frame_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } tx_byte_t;

  logic       clk_i              = 1'b0;
  logic       rst_ni             = 1'b0;
  logic       cfg_we_i           = 1'b0;
  logic [2:0] cfg_idx_i          = efb_pkg::CFG_START;
  logic [7:0] cfg_data_i         = 8'h00;
  logic       in_valid_i         = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i             = efb_pkg::MODE_HEADER;
  logic [7:0] command_code_i     = 8'h00;
  logic [7:0] kind_of_frame_i    = 8'h00;
  logic       use_given_number_i = 1'b0;
  logic [7:0] given_number_i     = 8'h00;
  logic [7:0] data_byte_i        = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i        = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  escaped_frame_builder_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .command_code_i     (command_code_i),
    .kind_of_frame_i    (kind_of_frame_i),
    .use_given_number_i (use_given_number_i),
    .given_number_i     (given_number_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .last_of_run_o      (last_of_run_o)
  );

  // shadow registers and state of the framer
  logic [7:0] sh_start, sh_end, sh_escape, sh_esc_end, sh_esc_escape, sh_link_addr;
  logic [7:0] exp_counter = efb_pkg::COUNTER_RESET;
  logic [7:0] exp_sum     = 8'h00;

  frame_item_t pending_items[$];
  frame_item_t cur_item;
  logic [7:0]  tx_run[$];
  tx_byte_t    tx_expected[$];
  tx_byte_t    head_byte;

  bit holding = 1'b0;
  bit idle_en = 1'b1;
  int tx_gap, rx_gap, quiet_cycles;
  int errors, items_sent, bytes_checked, stuffed_bytes, frames_built, counter_headers;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    errors++;
    $display("%0t mismatch on %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  task automatic stuff_content(input logic [7:0] b);
    exp_sum = exp_sum + b;
    if (b == sh_end) begin
      tx_run.push_back(sh_escape);
      tx_run.push_back(sh_esc_end);
      stuffed_bytes++;
    end else if (b == sh_escape) begin
      tx_run.push_back(sh_escape);
      tx_run.push_back(sh_esc_escape);
      stuffed_bytes++;
    end else begin
      tx_run.push_back(b);
    end
  endtask

  task automatic predict_frame_bytes(input frame_item_t it);
    logic [7:0] number;
    tx_byte_t   tb;
    tx_run.delete();
    case (it.mode)
      efb_pkg::MODE_HEADER: begin
        exp_sum = 8'h00;
        tx_run.push_back(sh_start);
        if (it.use_given) begin
          number = it.given;
        end else begin
          number = exp_counter;
          exp_counter = exp_counter + 8'd1;
        end
        stuff_content(sh_link_addr);
        stuff_content(number);
        stuff_content(it.kind);
        stuff_content(it.command);
      end
      efb_pkg::MODE_PAYLOAD: stuff_content(it.data);
      efb_pkg::MODE_TRAILER: begin
        stuff_content(exp_sum ^ efb_pkg::SUM_INVERT);
        tx_run.push_back(sh_end);
      end
      default: ;
    endcase
    foreach (tx_run[i]) begin
      tb.value = tx_run[i];
      tb.last  = (i == tx_run.size() - 1);
      tx_expected.push_back(tb);
    end
  endtask

  // sender: one item per handshake, random bursts of idle
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_frame_bytes(cur_item);
      if (cur_item.mode != efb_pkg::MODE_NONE) items_sent++;
      holding = 1'b0;
    end
    if (!in_valid_i || in_ready_o) begin
      if (tx_gap == 0 && idle_en && pending_items.size() > 0 && $urandom_range(0, 4) == 0)
        tx_gap = $urandom_range(1, 6);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        holding = 1'b1;
        in_valid_i         <= 1'b1;
        mode_i             <= cur_item.mode;
        command_code_i     <= cur_item.command;
        kind_of_frame_i    <= cur_item.kind;
        use_given_number_i <= cur_item.use_given;
        given_number_i     <= cur_item.given;
        data_byte_i        <= cur_item.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: check each wire byte against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (tx_expected.size() == 0) begin
        report_mismatch("byte with nothing expected", 8'h00, out_byte_o);
      end else begin
        head_byte = tx_expected.pop_front();
        bytes_checked++;
        if (out_byte_o !== head_byte.value)
          report_mismatch("out_byte", head_byte.value, out_byte_o);
        if (last_of_run_o !== head_byte.last)
          report_mismatch("last_of_run", {7'd0, head_byte.last}, {7'd0, last_of_run_o});
      end
    end
    if (rx_gap == 0 && idle_en && $urandom_range(0, 4) == 0)
      rx_gap = $urandom_range(1, 6);
    if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      efb_pkg::CFG_START:      sh_start      = val;
      efb_pkg::CFG_END:        sh_end        = val;
      efb_pkg::CFG_ESCAPE:     sh_escape     = val;
      efb_pkg::CFG_ESC_END:    sh_esc_end    = val;
      efb_pkg::CFG_ESC_ESCAPE: sh_esc_escape = val;
      efb_pkg::CFG_LINK_ADDR:  sh_link_addr  = val;
      default: ;
    endcase
  endtask

  task automatic load_codes(input logic [7:0] start_v, input logic [7:0] end_v,
                            input logic [7:0] esc_v, input logic [7:0] esc_end_v,
                            input logic [7:0] esc_esc_v, input logic [7:0] addr_v);
    write_reg(efb_pkg::CFG_START, start_v);
    write_reg(efb_pkg::CFG_END, end_v);
    write_reg(efb_pkg::CFG_ESCAPE, esc_v);
    write_reg(efb_pkg::CFG_ESC_END, esc_end_v);
    write_reg(efb_pkg::CFG_ESC_ESCAPE, esc_esc_v);
    write_reg(efb_pkg::CFG_LINK_ADDR, addr_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_codes();
    logic [7:0] end_v, esc_v;
    end_v = 8'($urandom);
    // now and then make end and escape collide
    esc_v = ($urandom_range(0, 3) == 0) ? end_v : 8'($urandom);
    load_codes(8'($urandom), end_v, esc_v, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // hold until the block has nothing left in flight
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pending_items.size() != 0 || holding || tx_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_item(input efb_pkg::mode_e m, input logic [7:0] command,
                            input logic [7:0] kind, input logic use_given,
                            input logic [7:0] given, input logic [7:0] data);
    frame_item_t it;
    it.mode      = m;
    it.command   = command;
    it.kind      = kind;
    it.use_given = use_given;
    it.given     = given;
    it.data      = data;
    pending_items.push_back(it);
  endtask

  // bias content toward the codes that need stuffing
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return sh_end;
      1: return sh_escape;
      2: return 8'h00;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_header();
    queue_item(efb_pkg::MODE_HEADER, pick_byte(), pick_byte(), 1'($urandom), pick_byte(),
               8'($urandom));
  endtask

  task automatic add_frame(input int payloads);
    add_header();
    repeat (payloads)
      queue_item(efb_pkg::MODE_PAYLOAD, 8'($urandom), 8'($urandom), 1'($urandom),
                 8'($urandom), pick_byte());
    queue_item(efb_pkg::MODE_TRAILER, 8'($urandom), 8'($urandom), 1'($urandom),
               8'($urandom), 8'($urandom));
    frames_built++;
  endtask

  task automatic add_random_items(input int count);
    int added, n;
    added = 0;
    while (added < count) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0: queue_item(efb_pkg::MODE_NONE, 8'($urandom), 8'($urandom), 1'($urandom),
                      8'($urandom), 8'($urandom));
        1: begin
          queue_item(efb_pkg::MODE_PAYLOAD, 8'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), pick_byte());
          added++;
        end
        2: begin
          queue_item(efb_pkg::MODE_TRAILER, 8'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), 8'($urandom));
          added++;
        end
        3: begin
          // abandoned frame: header with no trailer
          add_header();
          added++;
        end
        default: begin
          add_frame(n);
          added += n + 2;
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] hdr_sum, fill;
    sh_start = 8'h00; sh_end = 8'h00; sh_escape = 8'h00;
    sh_esc_end = 8'h00; sh_esc_escape = 8'h00; sh_link_addr = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all codes zero after reset; items outside any frame first
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'h7e);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_HEADER, 8'h00, 8'hff, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_NONE, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff);
    wait_idle();

    load_codes(8'h55, 8'hc0, 8'hdb, 8'hdc, 8'hdd, 8'h12);
    queue_item(efb_pkg::MODE_HEADER, 8'hff, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'hff);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, sh_end);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, sh_escape);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_HEADER, sh_end, sh_escape, 1'b1, sh_end, 8'h00);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    // second trailer sums in the previous checksum
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    // steer the checksum onto the end code, then onto the escape code
    hdr_sum = sh_link_addr + 8'h34 + 8'h01 + 8'h02;
    fill = ~sh_end - hdr_sum;
    queue_item(efb_pkg::MODE_HEADER, 8'h02, 8'h01, 1'b1, 8'h34, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, fill);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    fill = ~sh_escape - hdr_sum;
    queue_item(efb_pkg::MODE_HEADER, 8'h02, 8'h01, 1'b1, 8'h34, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, fill);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    // header in the middle of a frame restarts it
    queue_item(efb_pkg::MODE_HEADER, 8'h11, 8'h22, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'h5a);
    queue_item(efb_pkg::MODE_HEADER, 8'h33, 8'h44, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    wait_idle();

    // end and escape equal, every code but the escaped end code at the top of its range
    load_codes(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff);
    queue_item(efb_pkg::MODE_HEADER, 8'h00, 8'hff, 1'b1, 8'hff, 8'h00);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'hff);
    queue_item(efb_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(efb_pkg::MODE_TRAILER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    wait_idle();

    // run the frame counter through its wrap
    load_random_codes();
    repeat (260) begin
      queue_item(efb_pkg::MODE_HEADER, pick_byte(), pick_byte(), 1'b0, 8'($urandom),
                 8'($urandom));
      counter_headers++;
    end
    wait_idle();
    add_random_items(20);
    wait_idle();

    load_random_codes();
    add_random_items(25);
    wait_idle();

    // last stretch at full rate on both sides
    idle_en = 1'b0;
    load_random_codes();
    add_random_items(25);
    wait_idle();

    $display("sent %0d items (%0d random frames, %0d counter-only headers) over six code sets",
             items_sent, frames_built, counter_headers);
    $display("checked %0d wire bytes, %0d of them from stuffed content", bytes_checked,
             stuffed_bytes);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
